// ===== hdl/msp_pkg.sv =====
`timescale 1ns / 1ps
// Package for the MSP v1/v2 frame decoder: result type, protocol characters,
// result kind codes and the CRC-8 DVB-S2 byte step. No dependencies.
package msp_pkg;

	// Result kind codes.
	localparam logic [1:0] KindPayload  = 2'd0;
	localparam logic [1:0] KindGood     = 2'd1;
	localparam logic [1:0] KindBadCheck = 2'd2;
	localparam logic [1:0] KindOversize = 2'd3;

	// Protocol characters.
	localparam logic [7:0] ChDollar  = 8'h24;  // '$'
	localparam logic [7:0] ChM       = 8'h4D;  // 'M'
	localparam logic [7:0] ChX       = 8'h58;  // 'X'
	localparam logic [7:0] ChGt      = 8'h3E;  // '>'
	localparam logic [7:0] ChLt      = 8'h3C;  // '<'
	localparam logic [7:0] ChBang    = 8'h21;  // '!'
	localparam logic [7:0] JumboLen  = 8'hFF;
	localparam logic [7:0] CrcPoly   = 8'hD5;

	// Reset value of the payload length limit.
	localparam logic [15:0] MaxLenReset = 16'd1024;

	// One result beat.
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data_byte;
		logic [15:0] byte_index;
		logic [15:0] message_code;
		logic [15:0] payload_length;
		logic        is_version_two;
		logic        from_controller;
		logic        unsupported_mark;
	} msp_res_t;

	// CRC-8 DVB-S2 over one byte, unrolled over its eight bits.
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CrcPoly;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== hdl/msp_ifs.sv =====
`timescale 1ns / 1ps
// Channel interfaces of the MSP frame decoder: the received byte channel and
// the result channel. Both use a valid/ready handshake; no dependencies.
interface msp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

interface msp_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic [15:0] byte_index;
	logic [15:0] message_code;
	logic [15:0] payload_length;
	logic        is_version_two;
	logic        from_controller;
	logic        unsupported_mark;

	modport source(output valid, output kind, output data_byte, output byte_index,
		output message_code, output payload_length, output is_version_two,
		output from_controller, output unsupported_mark, input ready);
	modport sink(input valid, input kind, input data_byte, input byte_index,
		input message_code, input payload_length, input is_version_two,
		input from_controller, input unsupported_mark, output ready);
endinterface

// ===== hdl/msp_parser.sv =====
`timescale 1ns / 1ps
// MSP v1/v2 frame parser: state machine, running XOR / CRC-8 check and the
// length limit register. Uses msp_pkg and the msp_byte_if interface.
module msp_parser #(
	parameter int LENGTH_WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [15:0]      cfg_wr_data,
	msp_byte_if.sink         in_ch,
	input  logic             down_ready,
	output logic             res_valid,
	output msp_pkg::msp_res_t res
);
	import msp_pkg::*;

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_PROTO   = 5'd1;
	localparam logic [4:0] S_DIR_V1  = 5'd2;
	localparam logic [4:0] S_DIR_V2  = 5'd3;
	localparam logic [4:0] S_LEN_V1  = 5'd4;
	localparam logic [4:0] S_CODE_V1 = 5'd5;
	localparam logic [4:0] S_JLEN_LO = 5'd6;
	localparam logic [4:0] S_JLEN_HI = 5'd7;
	localparam logic [4:0] S_PAY_V1  = 5'd8;
	localparam logic [4:0] S_CHK_V1  = 5'd9;
	localparam logic [4:0] S_FLAG_V2 = 5'd10;
	localparam logic [4:0] S_CODE_LO = 5'd11;
	localparam logic [4:0] S_CODE_HI = 5'd12;
	localparam logic [4:0] S_LEN_LO  = 5'd13;
	localparam logic [4:0] S_LEN_HI  = 5'd14;
	localparam logic [4:0] S_PAY_V2  = 5'd15;
	localparam logic [4:0] S_CHK_V2  = 5'd16;

	// Largest length the byte counter can represent.
	localparam logic [15:0] LenCap = 16'((32'd1 << LENGTH_WIDTH) - 32'd1);

	logic [4:0]              state_q, state_nxt;
	logic [15:0]             code_q, code_nxt;
	logic [15:0]             exp_q, exp_nxt;
	logic [LENGTH_WIDTH-1:0] cnt_q, cnt_nxt;
	logic [7:0]              chk_q, chk_nxt;
	logic                    dir_q, dir_nxt;
	logic                    uns_q, uns_nxt;
	logic                    jumbo_q, jumbo_nxt;
	logic [15:0]             max_len_q;

	logic       accept;
	logic [7:0] b;
	logic       len_done;
	logic       len_v2;
	logic       emit;
	logic [1:0] kind;
	logic [7:0] data;
	logic [15:0] index;
	logic       v2;

	// The parser takes a beat whenever the output stage can hold its result.
	assign in_ch.ready = down_ready;
	assign accept      = in_ch.valid && down_ready;
	assign b           = in_ch.rx_byte;

	// Next-state and result logic for one received byte.
	always_comb begin
		state_nxt = state_q;
		code_nxt  = code_q;
		exp_nxt   = exp_q;
		cnt_nxt   = cnt_q;
		chk_nxt   = chk_q;
		dir_nxt   = dir_q;
		uns_nxt   = uns_q;
		jumbo_nxt = jumbo_q;
		len_done  = 1'b0;
		len_v2    = 1'b0;
		emit      = 1'b0;
		kind      = KindPayload;
		data      = 8'd0;
		index     = 16'd0;
		v2        = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (b == ChDollar) begin
					state_nxt = S_PROTO;
				end
			end
			S_PROTO: begin
				jumbo_nxt = 1'b0;
				if (b == ChM) begin
					state_nxt = S_DIR_V1;
				end else if (b == ChX) begin
					state_nxt = S_DIR_V2;
				end else begin
					state_nxt = S_IDLE;
				end
			end
			S_DIR_V1, S_DIR_V2: begin
				// Unknown direction bytes leave the direction bit as it was.
				uns_nxt = 1'b0;
				if (b == ChGt) begin
					dir_nxt = 1'b1;
				end else if (b == ChLt) begin
					dir_nxt = 1'b0;
				end else if (b == ChBang) begin
					uns_nxt = 1'b1;
				end
				state_nxt = (state_q == S_DIR_V1) ? S_LEN_V1 : S_FLAG_V2;
			end
			S_LEN_V1: begin
				exp_nxt   = {8'd0, b};
				chk_nxt   = b;
				jumbo_nxt = (b == JumboLen);
				cnt_nxt   = '0;
				state_nxt = S_CODE_V1;
			end
			S_CODE_V1: begin
				code_nxt = {8'd0, b};
				chk_nxt  = chk_q ^ b;
				if (jumbo_q) begin
					state_nxt = S_JLEN_LO;
				end else begin
					len_done = 1'b1;
				end
			end
			S_JLEN_LO: begin
				exp_nxt   = {8'd0, b};
				chk_nxt   = chk_q ^ b;
				state_nxt = S_JLEN_HI;
			end
			S_JLEN_HI: begin
				exp_nxt  = {b, exp_q[7:0]};
				chk_nxt  = chk_q ^ b;
				len_done = 1'b1;
			end
			S_PAY_V1, S_PAY_V2: begin
				cnt_nxt = cnt_q + 1'b1;
				emit    = 1'b1;
				kind    = KindPayload;
				data    = b;
				index   = 16'(cnt_q);
				v2      = (state_q == S_PAY_V2);
				chk_nxt = v2 ? crc8_step(chk_q, b) : (chk_q ^ b);
				if (16'(cnt_nxt) >= exp_q) begin
					state_nxt = v2 ? S_CHK_V2 : S_CHK_V1;
				end
			end
			S_CHK_V1, S_CHK_V2: begin
				state_nxt = S_IDLE;
				emit      = 1'b1;
				kind      = (chk_q == b) ? KindGood : KindBadCheck;
				index     = 16'(cnt_q);
				v2        = (state_q == S_CHK_V2);
			end
			S_FLAG_V2: begin
				chk_nxt   = crc8_step(8'd0, b);
				state_nxt = S_CODE_LO;
			end
			S_CODE_LO: begin
				code_nxt  = {8'd0, b};
				chk_nxt   = crc8_step(chk_q, b);
				state_nxt = S_CODE_HI;
			end
			S_CODE_HI: begin
				code_nxt  = {b, code_q[7:0]};
				chk_nxt   = crc8_step(chk_q, b);
				state_nxt = S_LEN_LO;
			end
			S_LEN_LO: begin
				exp_nxt   = {8'd0, b};
				chk_nxt   = crc8_step(chk_q, b);
				state_nxt = S_LEN_HI;
			end
			S_LEN_HI: begin
				exp_nxt  = {b, exp_q[7:0]};
				chk_nxt  = crc8_step(chk_q, b);
				len_done = 1'b1;
				len_v2   = 1'b1;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase

		// Length and code are known: drop oversize frames, else start the payload or, for zero length, the check byte.
		if (len_done) begin
			cnt_nxt = '0;
			if (exp_nxt > max_len_q || exp_nxt > LenCap) begin
				state_nxt = S_IDLE;
				emit      = 1'b1;
				kind      = KindOversize;
				index     = 16'd0;
				v2        = len_v2;
			end else if (exp_nxt != 16'd0) begin
				state_nxt = len_v2 ? S_PAY_V2 : S_PAY_V1;
			end else begin
				state_nxt = len_v2 ? S_CHK_V2 : S_CHK_V1;
			end
		end
	end

	// Result beat toward the output stage.
	assign res_valid            = accept && emit;
	assign res.kind             = kind;
	assign res.data_byte        = data;
	assign res.byte_index       = index;
	assign res.message_code     = code_nxt;
	assign res.payload_length   = exp_nxt;
	assign res.is_version_two   = v2;
	assign res.from_controller  = dir_nxt;
	assign res.unsupported_mark = uns_nxt;

	// Parser state, updated on each accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= '0;
			exp_q   <= '0;
			cnt_q   <= '0;
			chk_q   <= '0;
			dir_q   <= 1'b0;
			uns_q   <= 1'b0;
			jumbo_q <= 1'b0;
		end else if (accept) begin
			state_q <= state_nxt;
			code_q  <= code_nxt;
			exp_q   <= exp_nxt;
			cnt_q   <= cnt_nxt;
			chk_q   <= chk_nxt;
			dir_q   <= dir_nxt;
			uns_q   <= uns_nxt;
			jumbo_q <= jumbo_nxt;
		end
	end

	// Payload length limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MaxLenReset;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

endmodule

// ===== hdl/msp_out_stage.sv =====
`timescale 1ns / 1ps
// Output register of the MSP frame decoder: holds one result beat until the
// sink takes it. Uses msp_pkg and the msp_res_if interface.
module msp_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_valid,
	input  msp_pkg::msp_res_t res,
	output logic              up_ready,
	msp_res_if.source         out_ch
);
	import msp_pkg::*;

	logic     valid_q;
	msp_res_t data_q;

	// The register can load when it is empty or drained in this cycle.
	assign up_ready = !valid_q || out_ch.ready;

	// Valid flag of the held beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= res_valid;
		end
	end

	// Payload of the held beat.
	always_ff @(posedge clk) begin
		if (up_ready && res_valid) begin
			data_q <= res;
		end
	end

	assign out_ch.valid            = valid_q;
	assign out_ch.kind             = data_q.kind;
	assign out_ch.data_byte        = data_q.data_byte;
	assign out_ch.byte_index       = data_q.byte_index;
	assign out_ch.message_code     = data_q.message_code;
	assign out_ch.payload_length   = data_q.payload_length;
	assign out_ch.is_version_two   = data_q.is_version_two;
	assign out_ch.from_controller  = data_q.from_controller;
	assign out_ch.unsupported_mark = data_q.unsupported_mark;

endmodule

// ===== hdl/msp_v1_v2_frame_decoder_top.sv =====
`timescale 1ns / 1ps
// MSP v1/v2 frame decoder. A result beat appears in the cycle after the
// byte that causes it is accepted. Throughput: one byte per cycle; the parser
// state updates in the cycle of acceptance and a single output register holds
// the result, so a byte is taken whenever that register is empty or drains.
// Reset: arst_n clears the parser to idle and sets the length limit to 1024.
module msp_v1_v2_frame_decoder_top #(
	parameter int LENGTH_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	msp_byte_if.sink    in_ch,
	msp_res_if.source   out_ch
);
	import msp_pkg::*;

	logic     res_valid;
	msp_res_t res;
	logic     up_ready;

	// Frame parser.
	msp_parser #(
		.LENGTH_WIDTH(LENGTH_WIDTH)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_ch      (in_ch),
		.down_ready (up_ready),
		.res_valid  (res_valid),
		.res        (res)
	);

	// Result register.
	msp_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_valid(res_valid),
		.res      (res),
		.up_ready (up_ready),
		.out_ch   (out_ch)
	);

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for the MSP v1/v2 frame decoder: builds v1, jumbo and v2 frames with good
// and broken checks, decodes every accepted byte in a predictor of its own and compares
// each result beat. Depends on msp_pkg, msp_ifs.sv and msp_v1_v2_frame_decoder_top.
module tb_top;
	import msp_pkg::*;

	localparam int CycleLimit  = 600000;
	localparam int RandomBytes = 1100;
	localparam int HoldCycles  = 300;

	typedef enum logic [4:0] {
		S_IDLE, S_PROTO, S_DIR_V1, S_DIR_V2, S_LEN_V1, S_CODE_V1, S_JLEN_LO, S_JLEN_HI,
		S_PAY_V1, S_CHK_V1, S_FLAG_V2, S_CODE_LO, S_CODE_HI, S_LEN_LO, S_LEN_HI,
		S_PAY_V2, S_CHK_V2
	} parse_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;

	msp_byte_if byte_ch();
	msp_res_if  res_ch();

	msp_v1_v2_frame_decoder_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_ch      (byte_ch),
		.out_ch     (res_ch)
	);

	// Decoder state as the predictor keeps it.
	parse_t      pstate   = S_IDLE;
	logic [15:0] m_code   = '0;
	logic [15:0] m_len    = '0;
	logic [15:0] m_count  = '0;
	logic [7:0]  m_check  = '0;
	logic        m_dir    = 1'b0;
	logic        m_unsup  = 1'b0;
	logic        m_jumbo  = 1'b0;
	logic [15:0] m_limit  = MaxLenReset;

	msp_res_t beats_due[$];
	int       failures    = 0;
	int       cycle_count = 0;
	int       frame_bytes = 0;
	bit       idling      = 1'b1;
	bit       hold_req    = 1'b0;
	int       hold_left   = 0;
	int       stall_left  = 0;

	// Clock: 12 ns period.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Random gap length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		if (!idling) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	// CRC-8 DVB-S2, one byte folded in bit by bit.
	function automatic logic [7:0] crc_dvb(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] c;
		c = acc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
		end
		return c;
	endfunction

	function automatic msp_res_t make_beat(input logic [1:0] kind, input logic [7:0] data,
		input logic [15:0] idx, input logic v2);
		msp_res_t r;
		r.kind             = kind;
		r.data_byte        = data;
		r.byte_index       = idx;
		r.message_code     = m_code;
		r.payload_length   = m_len;
		r.is_version_two   = v2;
		r.from_controller  = m_dir;
		r.unsupported_mark = m_unsup;
		return r;
	endfunction

	// Length and code are known: drop as oversize, or go to payload or check byte.
	function automatic void header_done(input logic v2);
		m_count = '0;
		if (m_len > m_limit) begin
			beats_due.push_back(make_beat(KindOversize, 8'h00, 16'h0000, v2));
			pstate = S_IDLE;
		end else if (m_len != 0) begin
			pstate = v2 ? S_PAY_V2 : S_PAY_V1;
		end else begin
			pstate = v2 ? S_CHK_V2 : S_CHK_V1;
		end
	endfunction

	// Predictor: advances the frame parser by one received byte.
	function automatic void decode_rx_byte(input logic [7:0] b);
		logic v2;
		case (pstate)
			S_IDLE: begin
				if (b == ChDollar) begin
					pstate = S_PROTO;
				end
			end
			S_PROTO: begin
				m_jumbo = 1'b0;
				if (b == ChM) begin
					pstate = S_DIR_V1;
				end else if (b == ChX) begin
					pstate = S_DIR_V2;
				end else begin
					pstate = S_IDLE;
				end
			end
			S_DIR_V1, S_DIR_V2: begin
				// Any other direction byte leaves the direction bit as it was.
				m_unsup = 1'b0;
				if (b == ChGt) begin
					m_dir = 1'b1;
				end else if (b == ChLt) begin
					m_dir = 1'b0;
				end else if (b == ChBang) begin
					m_unsup = 1'b1;
				end
				pstate = (pstate == S_DIR_V1) ? S_LEN_V1 : S_FLAG_V2;
			end
			S_LEN_V1: begin
				m_len   = {8'h00, b};
				m_check = b;
				m_jumbo = (b == JumboLen);
				m_count = '0;
				pstate  = S_CODE_V1;
			end
			S_CODE_V1: begin
				m_code  = {8'h00, b};
				m_check = m_check ^ b;
				if (m_jumbo) begin
					pstate = S_JLEN_LO;
				end else begin
					header_done(1'b0);
				end
			end
			S_JLEN_LO: begin
				m_len   = {8'h00, b};
				m_check = m_check ^ b;
				pstate  = S_JLEN_HI;
			end
			S_JLEN_HI: begin
				m_len[15:8] = b;
				m_check     = m_check ^ b;
				header_done(1'b0);
			end
			S_PAY_V1, S_PAY_V2: begin
				v2 = (pstate == S_PAY_V2);
				beats_due.push_back(make_beat(KindPayload, b, m_count, v2));
				m_count = m_count + 16'd1;
				m_check = v2 ? crc_dvb(m_check, b) : (m_check ^ b);
				if (m_count >= m_len) begin
					pstate = v2 ? S_CHK_V2 : S_CHK_V1;
				end
			end
			S_CHK_V1, S_CHK_V2: begin
				v2 = (pstate == S_CHK_V2);
				beats_due.push_back(make_beat((m_check == b) ? KindGood : KindBadCheck,
					8'h00, m_count, v2));
				pstate = S_IDLE;
			end
			S_FLAG_V2: begin
				m_check = crc_dvb(8'h00, b);
				pstate  = S_CODE_LO;
			end
			S_CODE_LO: begin
				m_code  = {8'h00, b};
				m_check = crc_dvb(m_check, b);
				pstate  = S_CODE_HI;
			end
			S_CODE_HI: begin
				m_code[15:8] = b;
				m_check      = crc_dvb(m_check, b);
				pstate       = S_LEN_LO;
			end
			S_LEN_LO: begin
				m_len   = {8'h00, b};
				m_check = crc_dvb(m_check, b);
				pstate  = S_LEN_HI;
			end
			S_LEN_HI: begin
				m_len[15:8] = b;
				m_check     = crc_dvb(m_check, b);
				header_done(1'b1);
			end
			default: begin
				pstate = S_IDLE;
			end
		endcase
	endfunction

	// Sends one byte beat; entered and left at a falling edge.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_ch.valid   <= 1'b1;
		byte_ch.rx_byte <= b;
		@(posedge clk);
		while (!byte_ch.ready) begin
			@(posedge clk);
		end
		decode_rx_byte(b);
		@(negedge clk);
	endtask

	// Builds one frame. An oversize frame stops after its header, as the decoder drops it.
	task automatic send_frame(input bit v2, input logic [7:0] dir, input logic [15:0] code,
		input logic [15:0] len, input bit jumbo, input bit corrupt, input logic [7:0] flag);
		logic [7:0] bytes[$];
		logic [7:0] chk;
		logic [7:0] pay;
		bytes = '{ChDollar, v2 ? ChX : ChM, dir};
		if (v2) begin
			bytes.push_back(flag);
			bytes.push_back(code[7:0]);
			bytes.push_back(code[15:8]);
			bytes.push_back(len[7:0]);
			bytes.push_back(len[15:8]);
			chk = crc_dvb(crc_dvb(crc_dvb(crc_dvb(crc_dvb(8'h00, flag), code[7:0]),
				code[15:8]), len[7:0]), len[15:8]);
		end else if (jumbo) begin
			bytes.push_back(JumboLen);
			bytes.push_back(code[7:0]);
			bytes.push_back(len[7:0]);
			bytes.push_back(len[15:8]);
			chk = JumboLen ^ code[7:0] ^ len[7:0] ^ len[15:8];
		end else begin
			bytes.push_back(len[7:0]);
			bytes.push_back(code[7:0]);
			chk = len[7:0] ^ code[7:0];
		end
		if (len <= m_limit) begin
			for (int i = 0; i < len; i++) begin
				pay = $urandom;
				bytes.push_back(pay);
				chk = v2 ? crc_dvb(chk, pay) : (chk ^ pay);
			end
			if (corrupt) begin
				chk = chk ^ 8'($urandom_range(1, 255));
			end
			bytes.push_back(chk);
		end
		frame_bytes += bytes.size();
		foreach (bytes[i]) begin
			send_byte(bytes[i]);
		end
	endtask

	// Lowers valid and waits for every expected beat, plus the output register latency.
	task automatic wait_idle();
		byte_ch.valid <= 1'b0;
		while (beats_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic set_limit(input logic [15:0] v);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		m_limit = v;
	endtask

	// Garbage before the start mark, then a start mark with an unknown letter.
	task automatic test_noise();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(ChDollar);
		send_byte(8'h51);
	endtask

	// v1: one payload byte from the controller; an unknown direction with a bad check.
	task automatic test_v1_frames();
		send_frame(1'b0, ChGt, 16'h00FF, 16'd1, 1'b0, 1'b0, 8'h00);
		send_frame(1'b0, 8'h7A, 16'h0000, 16'd0, 1'b0, 1'b1, 8'h00);
	endtask

	// v2: unsupported reply with zero length, then a short frame towards the controller.
	task automatic test_v2_frames();
		send_frame(1'b1, ChBang, 16'hFFFF, 16'd0, 1'b0, 1'b0, 8'hA5);
		send_frame(1'b1, ChLt, 16'h1234, 16'd2, 1'b0, 1'b0, 8'h5A);
	endtask

	// Jumbo frames: zero length straight to the check byte, and a short one.
	task automatic test_jumbo();
		send_frame(1'b0, ChGt, 16'h0000, 16'd0, 1'b1, 1'b0, 8'h00);
		send_frame(1'b0, ChLt, 16'h0080, 16'd3, 1'b1, 1'b0, 8'h00);
	endtask

	// Length limit at its extremes and at an exact boundary.
	task automatic test_limit();
		set_limit(16'd0);
		send_frame(1'b0, ChGt, 16'h0011, 16'd1, 1'b0, 1'b0, 8'h00);
		send_frame(1'b1, ChGt, 16'h0022, 16'd0, 1'b0, 1'b0, 8'h01);
		set_limit(16'd5);
		send_frame(1'b1, ChLt, 16'h0033, 16'd5, 1'b0, 1'b0, 8'h02);
		send_frame(1'b0, ChLt, 16'h0044, 16'd6, 1'b1, 1'b0, 8'h00);
		send_frame(1'b1, ChGt, 16'h8000, 16'hFFFF, 1'b0, 1'b0, 8'h80);
		set_limit(16'hFFFF);
		send_frame(1'b0, ChGt, 16'h0055, 16'd300, 1'b1, 1'b0, 8'h00);
		set_limit(MaxLenReset);
	endtask

	// Receiver holds off for a long stretch while the sender keeps offering bytes.
	task automatic test_backpressure();
		wait_idle();
		idling   = 1'b0;
		hold_req = 1'b1;
		send_frame(1'b0, ChGt, 16'h0066, 16'd40, 1'b0, 1'b0, 8'h00);
		send_frame(1'b1, ChLt, 16'h0777, 16'd20, 1'b0, 1'b0, 8'h3C);
		idling = 1'b1;
	endtask

	// Mostly well-formed frames with random content, plus noise, bad letters and bad checks.
	task automatic test_random_traffic();
		int          start;
		int          next_phase;
		int          r;
		bit          v2;
		bit          jumbo;
		logic [7:0]  dir;
		logic [15:0] len;
		logic [7:0]  nb;
		start      = frame_bytes;
		next_phase = start + 300;
		while (frame_bytes - start < RandomBytes) begin
			if (frame_bytes >= next_phase) begin
				next_phase = frame_bytes + 300;
				idling = ($urandom_range(0, 3) != 0);
				case ($urandom_range(0, 5))
					0: set_limit(16'd0);
					1: set_limit(16'd3);
					2: set_limit(16'd8);
					3: set_limit(16'hFFFF);
					4: set_limit(16'($urandom_range(0, 300)));
					default: set_limit(MaxLenReset);
				endcase
			end
			r = $urandom_range(0, 99);
			if (r < 6) begin
				repeat ($urandom_range(1, 4)) begin
					nb = $urandom;
					send_byte((nb == ChDollar) ? 8'h00 : nb);
				end
			end else if (r < 9) begin
				send_byte(ChDollar);
				nb = $urandom;
				send_byte((nb == ChM || nb == ChX || nb == ChDollar) ? 8'hA0 : nb);
			end else begin
				v2    = (r < 52);
				jumbo = !v2 && (r >= 85);
				case ($urandom_range(0, 7))
					0, 1, 2: dir = ChGt;
					3, 4, 5: dir = ChLt;
					6:       dir = ChBang;
					default: dir = $urandom;
				endcase
				if ($urandom_range(0, 19) == 0) begin
					len = $urandom_range(9, (v2 || jumbo) ? 300 : 254);
				end else begin
					len = $urandom_range(0, 8);
				end
				send_frame(v2, dir, v2 ? 16'($urandom) : 16'($urandom_range(0, 255)), len,
					jumbo, $urandom_range(0, 9) == 0, $urandom);
			end
		end
		idling = 1'b1;
	endtask

	// Result side: random stalls, and the long hold-off when one is requested.
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HoldCycles;
		end
		if (hold_left > 0) begin
			res_ch.ready <= 1'b0;
			hold_left--;
		end else if (stall_left > 0) begin
			res_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			res_ch.ready <= 1'b1;
			stall_left = pick_gap();
		end
	end

	task automatic check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			failures++;
		end
	endtask

	// Each accepted result beat against the oldest expectation.
	always @(posedge clk) begin
		msp_res_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (beats_due.size() == 0) begin
				$error("unexpected result beat: kind %0h code %0h", res_ch.kind,
					res_ch.message_code);
				failures++;
			end else begin
				want = beats_due.pop_front();
				check_field("kind", want.kind, res_ch.kind);
				check_field("data_byte", want.data_byte, res_ch.data_byte);
				check_field("byte_index", want.byte_index, res_ch.byte_index);
				check_field("message_code", want.message_code, res_ch.message_code);
				check_field("payload_length", want.payload_length, res_ch.payload_length);
				check_field("is_version_two", want.is_version_two, res_ch.is_version_two);
				check_field("from_controller", want.from_controller, res_ch.from_controller);
				check_field("unsupported_mark", want.unsupported_mark,
					res_ch.unsupported_mark);
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		arst_n          = 1'b0;
		cfg_wr_en       = 1'b0;
		cfg_wr_data     = '0;
		byte_ch.valid   = 1'b0;
		byte_ch.rx_byte = '0;
		res_ch.ready    = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_noise();
		test_v1_frames();
		test_v2_frames();
		test_jumbo();
		test_limit();
		test_backpressure();
		test_random_traffic();
		wait_idle();
		repeat (5) @(negedge clk);
		if (failures == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
